[hw/rtl/ukvt_pkg.sv]
// Package for the unsorted key/value table.
// Holds the request and result item types, action codes and status codes.
// No dependencies.
package ukvt_pkg;

  localparam int KEY_WIDTH   = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int TOTAL_WIDTH = 5;

  // Action codes
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_SEARCH = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_SUCC   = 3'd3;
  localparam logic [2:0] ACT_PRED   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0]            action;
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] value;
  } ukvt_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [DATA_WIDTH-1:0]  found_value;
    logic [KEY_WIDTH-1:0]   neighbor_key;
    logic [TOTAL_WIDTH-1:0] entry_total;
    logic [KEY_WIDTH-1:0]   smallest_key;
    logic [KEY_WIDTH-1:0]   largest_key;
    logic                   is_empty;
  } ukvt_rsp_t;

endpackage

[hw/rtl/unsorted_key_value_table.sv]
// Unsorted key/value table: up to CAPACITY unique pairs kept in arrival order.
// Each item goes through a single scan over the key/value memory at one entry
// per cycle, which also tracks the minimum, maximum and neighbor keys, then a
// finish step and, for a remove that hits, a shift pass that moves one later
// entry per cycle down over the removed pair. The input stalls from acceptance
// until the result is handed to the output register. A finished result waits
// there while the next item is accepted, and a stalled output holds up the
// handoff. Depends on ukvt_pkg.
module unsorted_key_value_table
  import ukvt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ukvt_req_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ukvt_rsp_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_FINISH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  // Pair storage
  logic [KEY_WIDTH-1:0]  key_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic [KEY_WIDTH-1:0]  rd_key_r;
  logic [DATA_WIDTH-1:0] rd_val_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [KEY_WIDTH-1:0]  mem_wkey;
  logic [DATA_WIDTH-1:0] mem_wval;

  logic [2:0]            state_r, state_nxt;
  logic [2:0]            act_r, act_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]         lim_r, lim_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic                  pend_r, pend_nxt;
  logic                  hit_r, hit_nxt;
  logic [DATA_WIDTH-1:0] fval_r, fval_nxt;
  logic                  mm_have_r, mm_have_nxt;
  logic [KEY_WIDTH-1:0]  lo_r, lo_nxt;
  logic [KEY_WIDTH-1:0]  hi_r, hi_nxt;
  logic                  nb_have_r, nb_have_nxt;
  logic [KEY_WIDTH-1:0]  nb_r, nb_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic [DATA_WIDTH-1:0] res_fval_r, res_fval_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ukvt_rsp_t             out_data_r, out_data_nxt;

  logic                  scan_more;
  logic                  shift_more;
  logic                  excl;
  logic                  nb_take;
  logic [CW-1:0]         wr_idx;
  logic [CW+TOTAL_WIDTH-1:0] count_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign scan_more  = (idx_r < count_r);
  assign shift_more = (idx_r < lim_r);
  assign wr_idx     = rd_idx_r - CW'(1);
  assign count_ext  = {{TOTAL_WIDTH{1'b0}}, count_r};

  // Scan data: skip the key being removed when tracking min and max
  assign excl = (act_r == ACT_REMOVE) && (rd_key_r == key_r);

  // Neighbor candidate from the entry read last cycle
  always_comb begin
    nb_take = 1'b0;
    if (act_r == ACT_SUCC) begin
      nb_take = (rd_key_r > key_r) && (!nb_have_r || (rd_key_r < nb_r));
    end else if (act_r == ACT_PRED) begin
      nb_take = (rd_key_r < key_r) && (!nb_have_r || (rd_key_r > nb_r));
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      val_mem[mem_waddr] <= mem_wval;
    end
    rd_key_r <= key_mem[idx_r[AW-1:0]];
    rd_val_r <= val_mem[idx_r[AW-1:0]];
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    lim_nxt        = lim_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    fval_nxt       = fval_r;
    mm_have_nxt    = mm_have_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    nb_have_nxt    = nb_have_r;
    nb_nxt         = nb_r;
    res_status_nxt = res_status_r;
    res_fval_nxt   = res_fval_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_idx[AW-1:0];
    mem_wkey       = rd_key_r;
    mem_wval       = rd_val_r;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Latch the item and clear the scan trackers
        if (in_valid) begin
          act_nxt     = in_data.action;
          key_nxt     = in_data.key;
          val_nxt     = in_data.value;
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          hit_nxt     = 1'b0;
          fval_nxt    = '0;
          mm_have_nxt = 1'b0;
          lo_nxt      = '0;
          hi_nxt      = '0;
          nb_have_nxt = 1'b0;
          nb_nxt      = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        // Compare the entry read last cycle
        if (pend_r) begin
          if ((rd_key_r == key_r) && !hit_r) begin
            hit_nxt  = 1'b1;
            pos_nxt  = rd_idx_r;
            fval_nxt = rd_val_r;
          end
          if (!excl) begin
            mm_have_nxt = 1'b1;
            if (!mm_have_r || (rd_key_r < lo_r)) lo_nxt = rd_key_r;
            if (!mm_have_r || (rd_key_r > hi_r)) hi_nxt = rd_key_r;
          end
          if (nb_take) begin
            nb_have_nxt = 1'b1;
            nb_nxt      = rd_key_r;
          end
        end
        // Advance the read address
        pend_nxt = scan_more;
        if (scan_more) begin
          idx_nxt    = idx_r + CW'(1);
          rd_idx_nxt = idx_r;
        end else if (!pend_r) begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        res_status_nxt = ST_NONE;
        res_fval_nxt   = '0;
        state_nxt      = S_EMIT;
        case (act_r)
          ACT_INSERT: begin
            if (hit_r) begin
              res_status_nxt = ST_DUP;
            end else if (count_r >= CW'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
            end else begin
              // Append the pair and fold its key into min and max
              mem_we         = 1'b1;
              mem_waddr      = count_r[AW-1:0];
              mem_wkey       = key_r;
              mem_wval       = val_r;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = ST_OK;
              mm_have_nxt    = 1'b1;
              if (!mm_have_r || (key_r < lo_r)) lo_nxt = key_r;
              if (!mm_have_r || (key_r > hi_r)) hi_nxt = key_r;
            end
          end
          ACT_SEARCH: begin
            if (hit_r) begin
              res_status_nxt = ST_OK;
              res_fval_nxt   = fval_r;
            end
          end
          ACT_REMOVE: begin
            if (hit_r) begin
              // Shift later entries down over the removed one
              res_status_nxt = ST_OK;
              res_fval_nxt   = fval_r;
              count_nxt      = count_r - CW'(1);
              lim_nxt        = count_r;
              idx_nxt        = pos_r + CW'(1);
              pend_nxt       = 1'b0;
              state_nxt      = S_SHIFT;
            end
          end
          ACT_SUCC, ACT_PRED: begin
            if (nb_have_r) res_status_nxt = ST_OK;
          end
          default: begin
            res_status_nxt = ST_NONE;
          end
        endcase
      end

      S_SHIFT: begin
        // Write the entry read last cycle one place lower
        if (pend_r) begin
          mem_we = 1'b1;
        end
        pend_nxt = shift_more;
        if (shift_more) begin
          idx_nxt    = idx_r + CW'(1);
          rd_idx_nxt = idx_r;
        end else if (!pend_r) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        // Hand the result to the output register when it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.found_value  = res_fval_r;
          out_data_nxt.neighbor_key = nb_r;
          out_data_nxt.entry_total  = count_ext[TOTAL_WIDTH-1:0];
          out_data_nxt.smallest_key = mm_have_r ? lo_r : '0;
          out_data_nxt.largest_key  = mm_have_r ? hi_r : '0;
          out_data_nxt.is_empty     = (count_r == '0);
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and tracker registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    lim_r        <= lim_nxt;
    pos_r        <= pos_nxt;
    hit_r        <= hit_nxt;
    fval_r       <= fval_nxt;
    mm_have_r    <= mm_have_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    nb_have_r    <= nb_have_nxt;
    nb_r         <= nb_nxt;
    res_status_r <= res_status_nxt;
    res_fval_r   <= res_fval_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted item did not start a scan");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result loaded outside the emit step");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_empty == (out_data_r.entry_total == '0)))
    else $error("empty flag disagrees with entry total");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.is_empty) |->
      (out_data_r.smallest_key <= out_data_r.largest_key))
    else $error("smallest key above largest key");

endmodule

[bench/unsorted_key_value_table_test.sv]
// Testbench for the unsorted key/value table: directed and random requests
// checked against an in-bench model of the table contents.
// Depends on ukvt_pkg and unsorted_key_value_table.
module unsorted_key_value_table_test;
  import ukvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int REPORT_LIMIT = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ukvt_req_t in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ukvt_rsp_t out_data;

  // Model of the stored pairs, updated on every accepted item
  logic [KEY_WIDTH-1:0]  model_keys[TABLE_DEPTH];
  logic [DATA_WIDTH-1:0] model_values[TABLE_DEPTH];
  int                    model_count = 0;

  ukvt_rsp_t pending_results[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;

  unsorted_key_value_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side at random unless a quiet stretch is running
  always @(negedge clk) begin
    if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 16);
    end
  end

  // Apply one request to the table model and return the result it yields
  function automatic ukvt_rsp_t apply_request(ukvt_req_t req);
    ukvt_rsp_t rsp;
    int        slot;
    bit        have;
    rsp = '0;
    rsp.status = ST_NONE;
    slot = -1;
    have = 1'b0;
    for (int i = 0; i < model_count; i++) begin
      if (slot < 0 && model_keys[i] == req.key) slot = i;
    end
    case (req.action)
      ACT_INSERT: begin
        if (slot >= 0) begin
          rsp.status = ST_DUP;
        end else if (model_count >= TABLE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          model_keys[model_count] = req.key;
          model_values[model_count] = req.value;
          model_count++;
          rsp.status = ST_OK;
        end
      end
      ACT_SEARCH: begin
        if (slot >= 0) begin
          rsp.found_value = model_values[slot];
          rsp.status = ST_OK;
        end
      end
      ACT_REMOVE: begin
        if (slot >= 0) begin
          rsp.found_value = model_values[slot];
          // close the gap left by the removed pair
          for (int i = slot + 1; i < model_count; i++) begin
            model_keys[i-1] = model_keys[i];
            model_values[i-1] = model_values[i];
          end
          model_count--;
          rsp.status = ST_OK;
        end
      end
      ACT_SUCC, ACT_PRED: begin
        for (int i = 0; i < model_count; i++) begin
          if (req.action == ACT_SUCC ? model_keys[i] > req.key : model_keys[i] < req.key) begin
            if (!have || (req.action == ACT_SUCC ? model_keys[i] < rsp.neighbor_key
                                                 : model_keys[i] > rsp.neighbor_key)) begin
              rsp.neighbor_key = model_keys[i];
              have = 1'b1;
            end
          end
        end
        rsp.status = have ? ST_OK : ST_NONE;
      end
      default: begin
      end
    endcase
    // extremes over what is left in the table
    for (int i = 0; i < model_count; i++) begin
      if (i == 0 || model_keys[i] < rsp.smallest_key) rsp.smallest_key = model_keys[i];
      if (i == 0 || model_keys[i] > rsp.largest_key) rsp.largest_key = model_keys[i];
    end
    rsp.entry_total = model_count[TOTAL_WIDTH-1:0];
    rsp.is_empty = (model_count == 0);
    return rsp;
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    ukvt_rsp_t want;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        pending_results.push_back(apply_request(in_data));
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result item: %p", out_data);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status || out_data.found_value !== want.found_value
              || out_data.neighbor_key !== want.neighbor_key
              || out_data.entry_total !== want.entry_total
              || out_data.smallest_key !== want.smallest_key
              || out_data.largest_key !== want.largest_key
              || out_data.is_empty !== want.is_empty) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch (expected/actual): status %0d/%0d found %h/%h neighbor %h/%h",
                       want.status, out_data.status, want.found_value, out_data.found_value,
                       want.neighbor_key, out_data.neighbor_key);
              $display("  total %0d/%0d min %h/%h max %h/%h empty %0b/%0b",
                       want.entry_total, out_data.entry_total, want.smallest_key,
                       out_data.smallest_key, want.largest_key, out_data.largest_key,
                       want.is_empty, out_data.is_empty);
            end
          end
        end
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_request(input logic [2:0] action, input logic [KEY_WIDTH-1:0] key,
                              input logic [DATA_WIDTH-1:0] value);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.action = action;
    in_data.key = key;
    in_data.value = value;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(ACT_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_SUCC, 32'h0000_0000, 32'h0);
    send_request(ACT_PRED, 32'hFFFF_FFFF, 32'h0);
    send_request(3'd7, 32'h1234_5678, 32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_key_extremes();
    send_request(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_INSERT, 32'h0000_0000, 32'h0000_1234);
    send_request(ACT_SUCC, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_PRED, 32'h0000_0000, 32'h0);
    send_request(ACT_SUCC, 32'h0000_0000, 32'h0);
    send_request(ACT_PRED, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_REMOVE, 32'h0000_0000, 32'h0);
    drain_results();
  endtask

  task automatic test_full_table();
    // one pair is left from before, so fifteen more fill the table
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      send_request(ACT_INSERT, 32'h0000_0100 + i, $urandom);
    end
    send_request(ACT_INSERT, 32'h5555_0000, 32'hA5A5_A5A5);
    // duplicate wins over full
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_REMOVE, 32'h0000_0105, 32'h0);
    send_request(ACT_SEARCH, 32'h0000_010F, 32'h0);
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int item_total);
    logic [KEY_WIDTH-1:0] key_pool[24];
    logic [KEY_WIDTH-1:0] key;
    logic [2:0]           action;
    int                   roll;
    bit                   filling;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    filling = 1'b0;
    for (int n = 0; n < item_total; n++) begin
      // alternate fill and drain phases so the table swings between empty and full
      if (n % 40 == 0) filling = ~filling;
      if (n == 150) no_idle = 1'b1;
      if (n == 250) no_idle = 1'b0;
      if (n == 300) drain_results();
      roll = $urandom_range(0, 99);
      if (filling) begin
        if (roll < 55) action = ACT_INSERT;
        else if (roll < 65) action = ACT_SEARCH;
        else if (roll < 75) action = ACT_REMOVE;
        else if (roll < 85) action = ACT_SUCC;
        else if (roll < 95) action = ACT_PRED;
        else action = 3'($urandom_range(5, 7));
      end else begin
        if (roll < 15) action = ACT_INSERT;
        else if (roll < 30) action = ACT_SEARCH;
        else if (roll < 70) action = ACT_REMOVE;
        else if (roll < 80) action = ACT_SUCC;
        else if (roll < 90) action = ACT_PRED;
        else action = 3'($urandom_range(5, 7));
      end
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
      send_request(action, key, $urandom);
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_empty_table();
    test_key_extremes();
    test_full_table();
    test_random_traffic(450);
    // give a stray result time to show up
    repeat (4 * TABLE_DEPTH) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ukvt_pkg.sv
hw/rtl/unsorted_key_value_table.sv
bench/unsorted_key_value_table_test.sv
